FILE: rtl/bldc_six_step_commutator_core_assert.svh
// Assertion macros used by the commutator back end.
`ifndef BLDC_SIX_STEP_COMMUTATOR_CORE_ASSERT_SVH
`define BLDC_SIX_STEP_COMMUTATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BSCC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bscc assertion failed");

// next-cycle implication
`define BSCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bscc assertion failed");

`else

`define BSCC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BSCC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/bscc_pkg.sv
// Types, constants and table functions of the six-step commutator.
package bscc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W = 5;

  // phase drive codes
  localparam logic [2:0] DRV_OFF  = 3'd0;
  localparam logic [2:0] DRV_HON  = 3'd1;
  localparam logic [2:0] DRV_LON  = 3'd2;
  localparam logic [2:0] DRV_HPWM = 3'd3;
  localparam logic [2:0] DRV_LPWM = 3'd4;

  localparam logic [1:0] BEMF_ALL = 2'd3;

  localparam logic [2:0] ADV_FWD [0:6] = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd1};
  localparam logic [2:0] ADV_BWD [0:6] = '{3'd0, 3'd6, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
  // watched phase per step: C A B C A B
  localparam logic [1:0] BEMF_PHASE_TAB [0:6] =
    '{2'd0, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1};

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_HALL        = 3'd1,
    OP_STEP        = 3'd2,
    OP_REALIGN_INV = 3'd3,
    OP_REALIGN_DIR = 3'd4,
    OP_NONE        = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_HALL       = 2'd0,
    MODE_SENSORLESS = 2'd1,
    MODE_LEARN      = 2'd2,
    MODE_TEST       = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_HALL_MAP     = 3'd0,
    REG_RUN_MODE     = 3'd1,
    REG_REVERSE      = 3'd2,
    REG_PWM_HIGH     = 3'd3,
    REG_DUTY_REQUEST = 3'd4,
    REG_DUTY_LIMIT   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] pat;
  } item_t;

  typedef struct packed {
    logic [17:0] hall_map;
    mode_t       run_mode;
    logic        reverse;
    logic        pwm_on_high_side;
    logic [15:0] duty_request;
    logic [15:0] duty_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] a;
    logic [2:0] b;
    logic [2:0] c;
  } drive_t;

  function automatic logic step_ok(input logic [2:0] s);
    return (s >= 3'd1) && (s <= 3'd6);
  endfunction

  // patterns 0 and 7 are invalid and read as pattern 1
  function automatic logic [2:0] clean_hall(input logic [2:0] raw);
    return step_ok(raw) ? raw : 3'd1;
  endfunction

  // entry for pattern p (1..6), mirrored to 7-p when running backward
  function automatic logic [2:0] map_lookup(input logic [17:0] m, input logic rev,
                                            input logic [2:0] p);
    logic [2:0] idx;
    logic [2:0] r;
    idx = rev ? (3'd7 - p) : p;
    r = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (idx == 3'(k)) r = m[3*(k-1) +: 3];
    end
    return r;
  endfunction

  // entries never hit keep the source value
  function automatic logic [17:0] invert_map(input logic [17:0] m);
    logic [17:0] r;
    logic [2:0]  e;
    r = m;
    for (int i = 1; i <= 6; i++) begin
      e = m[3*(i-1) +: 3];
      for (int k = 1; k <= 6; k++) begin
        if (e == 3'(k)) r[3*(k-1) +: 3] = 3'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] advance(input logic [2:0] s, input logic rev);
    logic [2:0] r;
    r = s;
    if (s <= 3'd6) r = rev ? ADV_BWD[s] : ADV_FWD[s];
    return r;
  endfunction

  function automatic drive_t drive_for(input logic [2:0] s, input logic hs);
    drive_t d;
    unique case (s)
      3'd1: d = hs ? drive_t'{DRV_HPWM, DRV_LON, DRV_OFF} : drive_t'{DRV_HON, DRV_LPWM, DRV_OFF};
      3'd2: d = hs ? drive_t'{DRV_OFF, DRV_LON, DRV_HPWM} : drive_t'{DRV_OFF, DRV_LPWM, DRV_HON};
      3'd3: d = hs ? drive_t'{DRV_LON, DRV_OFF, DRV_HPWM} : drive_t'{DRV_LPWM, DRV_OFF, DRV_HON};
      3'd4: d = hs ? drive_t'{DRV_LON, DRV_HPWM, DRV_OFF} : drive_t'{DRV_LPWM, DRV_HON, DRV_OFF};
      3'd5: d = hs ? drive_t'{DRV_OFF, DRV_HPWM, DRV_LON} : drive_t'{DRV_OFF, DRV_HON, DRV_LPWM};
      3'd6: d = hs ? drive_t'{DRV_HPWM, DRV_OFF, DRV_LON} : drive_t'{DRV_HON, DRV_OFF, DRV_LPWM};
      default: d = drive_t'{DRV_OFF, DRV_OFF, DRV_OFF};
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/bscc_if.sv
// Item channels of the commutator: command in, drive/status out.
interface bscc_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [2:0] hall_raw;

  modport source (output valid, op, hall_raw, input ready);
  modport sink (input valid, op, hall_raw, output ready);
endinterface

interface bscc_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase_a_drive;
  logic [2:0]  phase_b_drive;
  logic [2:0]  phase_c_drive;
  logic [2:0]  step;
  logic [1:0]  bemf_phase;
  logic        bemf_rising;
  logic [15:0] duty;
  logic [31:0] last_period;
  logic [31:0] edge_count;
  logic [17:0] learned_map;

  modport source (output valid, phase_a_drive, phase_b_drive, phase_c_drive, step,
                  bemf_phase, bemf_rising, duty, last_period, edge_count, learned_map,
                  input ready);
  modport sink (input valid, phase_a_drive, phase_b_drive, phase_c_drive, step,
                bemf_phase, bemf_rising, duty, last_period, edge_count, learned_map,
                output ready);
endinterface

FILE: rtl/bscc_cfg.sv
// APB register file holding the commutator configuration.
module bscc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bscc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output bscc_pkg::cfg_t               cfg
);

  bscc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = bscc_pkg::reg_idx_t'(paddr[bscc_pkg::PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hall_map         <= '0;
      cfg.run_mode         <= bscc_pkg::MODE_HALL;
      cfg.reverse          <= 1'b0;
      cfg.pwm_on_high_side <= 1'b0;
      cfg.duty_request     <= '0;
      cfg.duty_limit       <= 16'hFFFF;
    end else if (wr_en) begin
      unique case (idx)
        bscc_pkg::REG_HALL_MAP:     cfg.hall_map         <= pwdata[17:0];
        bscc_pkg::REG_RUN_MODE:     cfg.run_mode         <= bscc_pkg::mode_t'(pwdata[1:0]);
        bscc_pkg::REG_REVERSE:      cfg.reverse          <= pwdata[0];
        bscc_pkg::REG_PWM_HIGH:     cfg.pwm_on_high_side <= pwdata[0];
        bscc_pkg::REG_DUTY_REQUEST: cfg.duty_request     <= pwdata[15:0];
        bscc_pkg::REG_DUTY_LIMIT:   cfg.duty_limit       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bscc_pkg::REG_HALL_MAP:     prdata = 32'(cfg.hall_map);
      bscc_pkg::REG_RUN_MODE:     prdata = 32'(cfg.run_mode);
      bscc_pkg::REG_REVERSE:      prdata = 32'(cfg.reverse);
      bscc_pkg::REG_PWM_HIGH:     prdata = 32'(cfg.pwm_on_high_side);
      bscc_pkg::REG_DUTY_REQUEST: prdata = 32'(cfg.duty_request);
      bscc_pkg::REG_DUTY_LIMIT:   prdata = 32'(cfg.duty_limit);
      default:                    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/bscc_front.sv
// Front end: takes command items, decodes the operation and cleans the hall pattern.
module bscc_front (
  bscc_cmd_if.sink              cmd,
  input  logic                  full,
  output logic                  push,
  output bscc_pkg::item_t       push_item
);

  bscc_pkg::op_t kind;

  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  always_comb begin
    unique case (cmd.op)
      bscc_pkg::OP_TICK:        kind = bscc_pkg::OP_TICK;
      bscc_pkg::OP_HALL:        kind = bscc_pkg::OP_HALL;
      bscc_pkg::OP_STEP:        kind = bscc_pkg::OP_STEP;
      bscc_pkg::OP_REALIGN_INV: kind = bscc_pkg::OP_REALIGN_INV;
      bscc_pkg::OP_REALIGN_DIR: kind = bscc_pkg::OP_REALIGN_DIR;
      default:                  kind = bscc_pkg::OP_NONE;
    endcase
  end

  assign push_item.op  = kind;
  assign push_item.pat = bscc_pkg::clean_hall(cmd.hall_raw);

endmodule

FILE: rtl/bscc_fifo.sv
// Short queue between the front end and the execution back end.
module bscc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bscc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output bscc_pkg::item_t pop_item,
  output logic            empty
);

  localparam logic [bscc_pkg::QPTR_W-1:0] PTR_LAST = bscc_pkg::QPTR_W'(bscc_pkg::QUEUE_DEPTH - 1);

  bscc_pkg::item_t               slots [bscc_pkg::QUEUE_DEPTH];
  logic [bscc_pkg::QPTR_W-1:0]   wr_ptr;
  logic [bscc_pkg::QPTR_W-1:0]   rd_ptr;
  logic [bscc_pkg::QCNT_W-1:0]   count;

  assign full     = (count == bscc_pkg::QCNT_W'(bscc_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

FILE: rtl/bscc_back.sv
// Back end: executes queued items on the commutation state and registers the result.
`include "bldc_six_step_commutator_core_assert.svh"

module bscc_back (
  input  logic            clk,
  input  logic            rst,
  input  bscc_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  bscc_pkg::item_t q_item,
  output logic            pop,
  bscc_rsp_if.source      rsp
);

  logic [2:0]                     step_reg, step_next;
  bscc_pkg::drive_t               drive, drive_next;
  logic [1:0]                     bemf_phase, bemf_phase_next;
  logic                           bemf_rising, bemf_rising_next;
  logic [bscc_pkg::COUNT_WIDTH-1:0] elapsed, elapsed_next;
  logic [bscc_pkg::COUNT_WIDTH-1:0] period, period_next;
  logic [31:0]                    edges, edges_next;
  logic [2:0]                     prev_hall, prev_hall_next;
  logic [17:0]                    learned, learned_next;

  logic [2:0]  fwd_step;
  logic [2:0]  inv_step;
  logic [2:0]  adv_step;
  logic        do_comm;
  logic        do_bemf;
  logic [31:0] period_out;

  assign pop = q_valid && (!rsp.valid || rsp.ready);

  assign fwd_step = bscc_pkg::map_lookup(cfg.hall_map, cfg.reverse, q_item.pat);
  assign inv_step = bscc_pkg::map_lookup(bscc_pkg::invert_map(cfg.hall_map), cfg.reverse,
                                         q_item.pat);
  assign adv_step = bscc_pkg::advance(step_reg, cfg.reverse);

  always_comb begin
    step_next        = step_reg;
    drive_next       = drive;
    bemf_phase_next  = bemf_phase;
    bemf_rising_next = bemf_rising;
    elapsed_next     = elapsed;
    period_next      = period;
    edges_next       = edges;
    prev_hall_next   = prev_hall;
    learned_next     = learned;
    do_comm          = 1'b0;
    do_bemf          = 1'b0;

    unique case (q_item.op)
      bscc_pkg::OP_TICK: begin
        if (elapsed != bscc_pkg::CNT_MAX) elapsed_next = elapsed + bscc_pkg::CNT_ONE;
      end
      bscc_pkg::OP_HALL: begin
        unique case (cfg.run_mode)
          bscc_pkg::MODE_HALL: begin
            step_next = fwd_step;
            do_comm   = 1'b1;
          end
          bscc_pkg::MODE_SENSORLESS: begin
            step_next = adv_step;
            do_comm   = 1'b1;
            do_bemf   = 1'b1;
          end
          bscc_pkg::MODE_LEARN: begin
            // record the previous pattern against the current step
            for (int i = 1; i <= 6; i++) begin
              if (step_reg == 3'(i)) learned_next[3*(i-1) +: 3] = prev_hall;
            end
            prev_hall_next = q_item.pat;
          end
          bscc_pkg::MODE_TEST: ;
          default: ;
        endcase
        period_next  = elapsed;
        elapsed_next = '0;
        edges_next   = edges + 32'd1;
      end
      bscc_pkg::OP_STEP: begin
        step_next = adv_step;
        do_comm   = 1'b1;
      end
      bscc_pkg::OP_REALIGN_INV: begin
        step_next = inv_step;
        do_comm   = 1'b1;
      end
      bscc_pkg::OP_REALIGN_DIR: begin
        step_next = fwd_step;
        do_comm   = 1'b1;
      end
      bscc_pkg::OP_NONE: ;
      default: ;
    endcase

    // an out-of-range step leaves drive and back-EMF selection alone
    if (do_comm && bscc_pkg::step_ok(step_next)) begin
      drive_next = bscc_pkg::drive_for(step_next, cfg.pwm_on_high_side);
    end
    if (do_bemf && bscc_pkg::step_ok(step_next)) begin
      bemf_phase_next  = bscc_pkg::BEMF_PHASE_TAB[step_next];
      bemf_rising_next = step_next[0] ^ cfg.reverse;
    end
  end

  if (bscc_pkg::COUNT_WIDTH > 32) begin : g_period_sat
    assign period_out = (|period_next[bscc_pkg::COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF
                                                                   : period_next[31:0];
  end else begin : g_period_ext
    assign period_out = 32'(period_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg    <= 3'd1;
      drive       <= bscc_pkg::drive_t'{bscc_pkg::DRV_OFF, bscc_pkg::DRV_OFF,
                                        bscc_pkg::DRV_OFF};
      bemf_phase  <= bscc_pkg::BEMF_ALL;
      bemf_rising <= 1'b0;
      elapsed     <= '0;
      period      <= '0;
      edges       <= '0;
      prev_hall   <= '0;
      learned     <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (pop) begin
        step_reg    <= step_next;
        drive       <= drive_next;
        bemf_phase  <= bemf_phase_next;
        bemf_rising <= bemf_rising_next;
        elapsed     <= elapsed_next;
        period      <= period_next;
        edges       <= edges_next;
        prev_hall   <= prev_hall_next;
        learned     <= learned_next;
        rsp.valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // result register, loaded with the post-item state
  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.phase_a_drive <= drive_next.a;
      rsp.phase_b_drive <= drive_next.b;
      rsp.phase_c_drive <= drive_next.c;
      rsp.step          <= step_next;
      rsp.bemf_phase    <= bemf_phase_next;
      rsp.bemf_rising   <= bemf_rising_next;
      rsp.duty          <= (cfg.duty_request > cfg.duty_limit) ? cfg.duty_limit
                                                                : cfg.duty_request;
      rsp.last_period   <= period_out;
      rsp.edge_count    <= edges_next;
      rsp.learned_map   <= bscc_pkg::invert_map(learned_next);
    end
  end

  `BSCC_ASSERT_NEXT(a_hall_counts_edge, clk, rst, pop && q_item.op == bscc_pkg::OP_HALL, edges == $past(edges) + 32'd1)
  `BSCC_ASSERT_NEXT(a_idle_holds_state, clk, rst, !pop, $stable(step_reg) && $stable(edges) && $stable(elapsed))
  `BSCC_ASSERT_NEXT(a_pop_gives_result, clk, rst, pop, rsp.valid)
  `BSCC_ASSERT_IMPLIES(a_pop_needs_room, clk, rst, pop, !rsp.valid || rsp.ready)

endmodule

FILE: rtl/bldc_six_step_commutator_core.sv
// Six-step BLDC commutator. Each command item (tick, hall edge, manual step or
// realign) yields one result item with the three phase drive codes, step, back-EMF
// selection, clamped duty, last hall period, edge count and the learned map.
// Throughput is one item per clock while the result side accepts; a command is
// decoded into a two-entry queue, then the execution stage updates the step
// state and loads the result register. When the result side stalls the queue
// fills and cmd.ready drops once it holds two items.
// Registers sit on the APB port at byte addresses 0x00 hall_map, 0x04 run_mode,
// 0x08 reverse, 0x0C pwm_on_high_side, 0x10 duty_request, 0x14 duty_limit; write
// them only while no item is in flight.
module bldc_six_step_commutator_core (
  input  logic                         clk,
  input  logic                         rst,
  bscc_cmd_if.sink                     cmd,
  bscc_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bscc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  bscc_pkg::cfg_t  cfg;
  logic            push;
  bscc_pkg::item_t push_item;
  logic            full;
  logic            empty;
  logic            pop;
  bscc_pkg::item_t pop_item;

  bscc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bscc_front u_front (
    .cmd       (cmd),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  bscc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  bscc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (!empty),
    .q_item  (pop_item),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

FILE: test/bscc_status_checker.sv
// Status checker: tracks register writes, predicts every result item and compares it.
module bscc_status_checker
  import bscc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  bscc_cmd_if                cmd,
  bscc_rsp_if                rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int unsigned        mismatches,
  output int unsigned        in_flight
);

  typedef struct packed {
    logic [2:0]  phase_a;
    logic [2:0]  phase_b;
    logic [2:0]  phase_c;
    logic [2:0]  step;
    logic [1:0]  bemf_phase;
    logic        bemf_rising;
    logic [15:0] duty;
    logic [31:0] last_period;
    logic [31:0] edge_count;
    logic [17:0] learned_map;
  } status_t;

  // register shadow
  logic [17:0] map_word;
  mode_t       run_mode;
  logic        rev;
  logic        chop_high;
  logic [15:0] duty_req;
  logic [15:0] duty_max;

  // commutation state; tables hold entry i at bits 3*i+2:3*i, entry 0 unused
  logic [2:0]  cur_step;
  logic [8:0]  drv_word;
  logic [1:0]  bemf_ph;
  logic        bemf_up;
  logic [31:0] elapsed_ticks;
  logic [31:0] period_ticks;
  logic [31:0] edge_total;
  logic [2:0]  last_pattern;
  logic [20:0] learned_tbl;

  status_t status_due_q[$];

  function automatic logic legal_step(input logic [2:0] s);
    return (s >= 3'd1) && (s <= 3'd6);
  endfunction

  // hall-to-step table turned around; entries never hit keep their own value
  function automatic logic [20:0] invert_tbl(input logic [20:0] src);
    logic [20:0] dst;
    logic [2:0]  e;
    dst = src;
    for (int i = 1; i <= 6; i++) begin
      e = src[3*i +: 3];
      if (legal_step(e)) dst[3*e +: 3] = 3'(i);
    end
    return dst;
  endfunction

  function automatic logic [2:0] pick_entry(input logic [20:0] tbl, input logic [2:0] pat);
    int idx;
    idx = rev ? 7 - int'(pat) : int'(pat);
    return tbl[3*idx +: 3];
  endfunction

  // phase switched high and phase switched low for a step
  function automatic logic [3:0] hi_lo(input logic [2:0] s);
    case (s)
      3'd1: return {2'd0, 2'd1};
      3'd2: return {2'd2, 2'd1};
      3'd3: return {2'd2, 2'd0};
      3'd4: return {2'd1, 2'd0};
      3'd5: return {2'd1, 2'd2};
      3'd6: return {2'd0, 2'd2};
      default: return 4'd0;
    endcase
  endfunction

  task automatic load_drive();
    logic [1:0] hi, lo;
    if (legal_step(cur_step)) begin
      {hi, lo} = hi_lo(cur_step);
      drv_word = {3{DRV_OFF}};
      drv_word[3*hi +: 3] = chop_high ? DRV_HPWM : DRV_HON;
      drv_word[3*lo +: 3] = chop_high ? DRV_LON : DRV_LPWM;
    end
  endtask

  task automatic step_on();
    if (legal_step(cur_step)) begin
      if (rev) cur_step = (cur_step == 3'd1) ? 3'd6 : cur_step - 3'd1;
      else cur_step = (cur_step == 3'd6) ? 3'd1 : cur_step + 3'd1;
    end
  endtask

  // the floating phase is the one neither switched high nor low
  task automatic choose_bemf();
    logic [1:0] hi, lo;
    if (legal_step(cur_step)) begin
      {hi, lo} = hi_lo(cur_step);
      bemf_ph = 2'd3 - hi - lo;
      bemf_up = cur_step[0] ^ rev;
    end
  endtask

  task automatic apply_item(input logic [2:0] op, input logic [2:0] raw);
    logic [2:0] pat;
    pat = legal_step(raw) ? raw : 3'd1;
    case (op)
      OP_TICK: if (elapsed_ticks != '1) elapsed_ticks = elapsed_ticks + 1;
      OP_HALL: begin
        case (run_mode)
          MODE_HALL: begin
            cur_step = pick_entry({map_word, 3'd0}, pat);
            load_drive();
          end
          MODE_SENSORLESS: begin
            step_on();
            load_drive();
            choose_bemf();
          end
          MODE_LEARN: begin
            if (legal_step(cur_step)) learned_tbl[3*cur_step +: 3] = last_pattern;
            last_pattern = pat;
          end
          default: ;
        endcase
        period_ticks = elapsed_ticks;
        elapsed_ticks = '0;
        edge_total = edge_total + 1;
      end
      OP_STEP: begin
        step_on();
        load_drive();
      end
      OP_REALIGN_INV: begin
        cur_step = pick_entry(invert_tbl({map_word, 3'd0}), pat);
        load_drive();
      end
      OP_REALIGN_DIR: begin
        cur_step = pick_entry({map_word, 3'd0}, pat);
        load_drive();
      end
      default: ;
    endcase
  endtask

  function automatic status_t status_now();
    status_t s;
    logic [20:0] linv;
    linv = invert_tbl(learned_tbl);
    s.phase_a     = drv_word[2:0];
    s.phase_b     = drv_word[5:3];
    s.phase_c     = drv_word[8:6];
    s.step        = cur_step;
    s.bemf_phase  = bemf_ph;
    s.bemf_rising = bemf_up;
    s.duty        = (duty_req > duty_max) ? duty_max : duty_req;
    s.last_period = period_ticks;
    s.edge_count  = edge_total;
    s.learned_map = linv[20:3];
    return s;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      map_word      = '0;
      run_mode      = MODE_HALL;
      rev           = 1'b0;
      chop_high     = 1'b0;
      duty_req      = '0;
      duty_max      = '1;
      cur_step      = 3'd1;
      drv_word      = {3{DRV_OFF}};
      bemf_ph       = BEMF_ALL;
      bemf_up       = 1'b0;
      elapsed_ticks = '0;
      period_ticks  = '0;
      edge_total    = '0;
      last_pattern  = '0;
      learned_tbl   = '0;
      mismatches    = 0;
      status_due_q.delete();
      in_flight <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (status_due_q.size() == 0) begin
          $error("result item arrived with nothing expected");
          mismatches++;
        end else begin
          want = status_due_q.pop_front();
          check_field("phase_a_drive", 32'(want.phase_a), 32'(rsp.phase_a_drive));
          check_field("phase_b_drive", 32'(want.phase_b), 32'(rsp.phase_b_drive));
          check_field("phase_c_drive", 32'(want.phase_c), 32'(rsp.phase_c_drive));
          check_field("step", 32'(want.step), 32'(rsp.step));
          check_field("bemf_phase", 32'(want.bemf_phase), 32'(rsp.bemf_phase));
          check_field("bemf_rising", 32'(want.bemf_rising), 32'(rsp.bemf_rising));
          check_field("duty", 32'(want.duty), 32'(rsp.duty));
          check_field("last_period", want.last_period, rsp.last_period);
          check_field("edge_count", want.edge_count, rsp.edge_count);
          check_field("learned_map", 32'(want.learned_map), 32'(rsp.learned_map));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[PADDR_W-1:2]))
          REG_HALL_MAP:     map_word  = pwdata[17:0];
          REG_RUN_MODE:     run_mode  = mode_t'(pwdata[1:0]);
          REG_REVERSE:      rev       = pwdata[0];
          REG_PWM_HIGH:     chop_high = pwdata[0];
          REG_DUTY_REQUEST: duty_req  = pwdata[15:0];
          REG_DUTY_LIMIT:   duty_max  = pwdata[15:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        apply_item(cmd.op, cmd.hall_raw);
        status_due_q.push_back(status_now());
      end
      in_flight <= status_due_q.size();
    end
  end

endmodule

FILE: test/bldc_six_step_commutator_core_tb.sv
// Stimulus and verdict for the six-step commutator; prediction sits in bscc_status_checker.
module bldc_six_step_commutator_core_tb;
  import bscc_pkg::*;

  // codes past the last defined operation, ignored by the block
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 50;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               sink_ready = 1'b0;
  int unsigned        mismatches;
  int unsigned        in_flight;
  int                 sender_idle_pct = 20;
  int                 sink_idle_pct = 20;
  int                 stall_left = 0;

  bscc_cmd_if cmd_ch();
  bscc_rsp_if rsp_ch();

  assign rsp_ch.ready = sink_ready;

  bldc_six_step_commutator_core dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bscc_status_checker status_chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  always #5 clk = ~clk;

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [2:0] rand_pattern();
    if ($urandom_range(0, 99) < 85) return 3'($urandom_range(1, 6));
    return $urandom_range(0, 1) ? 3'd7 : 3'd0;
  endfunction

  function automatic logic [17:0] shuffled_map();
    logic [17:0] m;
    logic [2:0]  t;
    int          j;
    for (int i = 0; i < 6; i++) m[3*i +: 3] = 3'(i + 1);
    for (int i = 5; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = m[3*i +: 3];
      m[3*i +: 3] = m[3*j +: 3];
      m[3*j +: 3] = t;
    end
    return m;
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < sink_idle_pct) begin
      stall_left <= idle_len() - 1;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [2:0] op, input logic [2:0] hall);
    int gap;
    gap = ($urandom_range(0, 99) < sender_idle_pct) ? idle_len() : 0;
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.op       <= op;
    cmd_ch.hall_raw <= hall;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // hold off the sender until every predicted item has come back
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  task automatic set_phase(input int k);
    logic [17:0] hmap;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 55) hmap = shuffled_map();
    else if (r < 80) hmap = 18'($urandom);
    else if (r < 90) hmap = '0;
    else hmap = '1;
    apb_write(REG_HALL_MAP, 32'(hmap));
    apb_write(REG_RUN_MODE, 32'(mode_t'((k < 4) ? k : $urandom_range(0, 3))));
    apb_write(REG_REVERSE, 32'($urandom_range(0, 1)));
    apb_write(REG_PWM_HIGH, 32'($urandom_range(0, 1)));
    apb_write(REG_DUTY_REQUEST,
              (k == 0) ? 32'hFFFF : (k == 1) ? 32'h0 : 32'($urandom_range(0, 65535)));
    apb_write(REG_DUTY_LIMIT,
              (k == 0) ? 32'hFFFF : (k == 1) ? 32'h0 : 32'($urandom_range(0, 65535)));
    sender_idle_pct = (k % 3 == 0) ? 0 : 30;
    sink_idle_pct   = (k % 3 == 0) ? 0 : 25;
  endtask

  initial begin
    int sent;
    int r;
    int burst;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.op       <= OP_TICK;
    cmd_ch.hall_raw <= 3'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: all-zero hall map sends the step out of range
    send_item(OP_TICK, 3'd0);
    send_item(OP_TICK, 3'd7);
    send_item(OP_HALL, 3'd0);
    send_item(OP_STEP, 3'd5);
    send_item(OP_REALIGN_INV, 3'd3);
    drain_results();

    apb_write(REG_HALL_MAP, 32'({3'd2, 3'd6, 3'd1, 3'd4, 3'd3, 3'd5}));
    apb_write(REG_PWM_HIGH, 32'd1);
    apb_write(REG_DUTY_REQUEST, 32'hFFFF);
    apb_write(REG_DUTY_LIMIT, 32'h1234);
    for (int p = 1; p <= 6; p++) send_item(OP_HALL, 3'(p));
    send_item(OP_REALIGN_INV, 3'd7);
    send_item(OP_REALIGN_DIR, 3'd2);
    send_item(OP_STEP, 3'd0);
    send_item(OP_NONE, 3'd6);
    send_item(OP_RSVD7, 3'd1);
    drain_results();

    apb_write(REG_RUN_MODE, 32'(MODE_SENSORLESS));
    apb_write(REG_REVERSE, 32'd1);
    apb_write(REG_DUTY_LIMIT, 32'h0);
    send_item(OP_HALL, 3'd4);
    send_item(OP_HALL, 3'd5);
    send_item(OP_STEP, 3'd2);
    drain_results();

    apb_write(REG_RUN_MODE, 32'(MODE_LEARN));
    apb_write(REG_REVERSE, 32'd0);
    send_item(OP_HALL, 3'd1);
    send_item(OP_HALL, 3'd6);
    send_item(OP_STEP, 3'd3);
    send_item(OP_HALL, 3'd2);
    drain_results();

    apb_write(REG_RUN_MODE, 32'(MODE_TEST));
    send_item(OP_HALL, 3'd3);
    send_item(OP_RSVD6, 3'd4);

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      drain_results();
      set_phase(k);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          // runs of ticks build up a hall period
          burst = $urandom_range(1, 10);
          repeat (burst) send_item(OP_TICK, 3'($urandom_range(0, 7)));
          sent += burst;
        end else begin
          if (r < 70) send_item(OP_HALL, rand_pattern());
          else if (r < 80) send_item(OP_STEP, 3'($urandom_range(0, 7)));
          else if (r < 86) send_item(OP_REALIGN_INV, rand_pattern());
          else if (r < 92) send_item(OP_REALIGN_DIR, rand_pattern());
          else send_item(3'($urandom_range(OP_NONE, OP_RSVD7)), 3'($urandom_range(0, 7)));
          sent++;
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("bldc_six_step_commutator_core verification clean");
    end else begin
      $display("bldc_six_step_commutator_core verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("bldc_six_step_commutator_core verification failed");
    $finish;
  end

endmodule
